/* hw/rtl/gce_pkg.sv */
// Shared types and constants for the glyph column extent block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gce_pkg;

  localparam int GRID       = 8;
  localparam int GRID_W     = 3;
  localparam int SLOT_W     = 6;
  localparam int CODE_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int FRAC_W     = 16;
  localparam int FRAC_CNT_W = 5;

  localparam logic [GRID_W-1:0] GRID_LAST = 3'd7;

  // Input item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIT_THRESHOLD = 2'd2;

  localparam logic [CFG_DATA_W-1:0] CELL_WIDTH_RST    = 8'd32;
  localparam logic [CFG_DATA_W-1:0] CELL_HEIGHT_RST   = 8'd32;
  localparam logic [CFG_DATA_W-1:0] LIT_THRESHOLD_RST = 8'd8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic px_fire;
    logic px_lit;
    logic restart;
    logic clr_seen;
  } trk_ctrl_t;

  typedef struct packed {
    logic              band_end;
    logic [GRID_W-1:0] band;
  } trk_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/gce_divider.sv */
// Shared restoring divider: one quotient bit per cycle, 16 fraction bits.
// Depends on gce_pkg for the fraction width and iteration count width.
`timescale 1ns / 1ps
`default_nettype none

module gce_divider
  import gce_pkg::*;
#(
  parameter int LW = 7,
  parameter int WW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [LW-1:0]     dividend,
  input  wire logic [WW-1:0]     divisor,
  output logic                   idle,
  output logic [FRAC_W-1:0]      quotient
);

  logic [FRAC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WW-1:0]         rem_r, rem_nxt;
  logic [WW-1:0]         div_r;
  logic [FRAC_W-1:0]     q_r, q_nxt;
  logic [WW:0]           trial;
  logic                  take;

  // rem stays below the divisor, so its double fits in WW+1 bits
  assign trial = {rem_r, 1'b0};
  assign take  = (trial >= {1'b0, div_r});

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (start) begin
      cnt_nxt = FRAC_CNT_W'(FRAC_W);
      rem_nxt = WW'(dividend);
      q_nxt   = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = take ? WW'(trial - {1'b0, div_r}) : WW'(trial);
      q_nxt   = {q_r[FRAC_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign idle     = (cnt_r == '0);
  assign quotient = q_r;

endmodule

`default_nettype wire

/* hw/rtl/gce_tracker.sv */
// Raster position counters and per-cell leftmost/rightmost ink tracking.
// Depends on gce_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gce_tracker
  import gce_pkg::*;
#(
  parameter int LW = 7,
  parameter int WW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trk_ctrl_t         ctrl,
  input  wire logic [WW-1:0]     weff,
  input  wire logic [WW-1:0]     heff,
  input  wire logic [GRID_W-1:0] rd_idx,
  output trk_stat_t              stat,
  output logic                   rd_seen,
  output logic [LW-1:0]          rd_left,
  output logic [LW-1:0]          rd_right
);

  logic [LW-1:0]     col_r;
  logic [LW-1:0]     row_r;
  logic [GRID_W-1:0] cell_r;
  logic [GRID_W-1:0] band_r;
  logic [GRID-1:0]   seen_r;
  logic [LW-1:0]     left_r  [GRID];
  logic [LW-1:0]     right_r [GRID];

  logic              col_last;
  logic              row_last;
  logic [GRID_W-1:0] ridx;

  assign col_last = (WW'(col_r) == weff - 1'b1);
  assign row_last = (WW'(row_r) == heff - 1'b1);

  // one read port: the pixel path owns it while a pixel moves
  assign ridx     = ctrl.px_fire ? cell_r : rd_idx;
  assign rd_seen  = seen_r[ridx];
  assign rd_left  = left_r[ridx];
  assign rd_right = right_r[ridx];

  assign stat.band_end = ctrl.px_fire && col_last && (cell_r == GRID_LAST) && row_last;
  assign stat.band     = band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cell_r <= '0;
      band_r <= '0;
      seen_r <= '0;
    end else if (ctrl.restart) begin
      col_r  <= '0;
      row_r  <= '0;
      cell_r <= '0;
      band_r <= '0;
      seen_r <= '0;
    end else begin
      if (ctrl.clr_seen) begin
        seen_r <= '0;
      end
      if (ctrl.px_fire) begin
        if (ctrl.px_lit) begin
          seen_r[ridx] <= 1'b1;
        end
        if (!col_last) begin
          col_r <= col_r + 1'b1;
        end else begin
          col_r <= '0;
          if (cell_r != GRID_LAST) begin
            cell_r <= cell_r + 1'b1;
          end else begin
            cell_r <= '0;
            if (row_last) begin
              row_r  <= '0;
              band_r <= band_r + 1'b1;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end
        end
      end
    end
  end

  // extent registers are payload: only read behind a seen bit
  always_ff @(posedge clk) begin
    if (ctrl.px_fire && ctrl.px_lit) begin
      if (!rd_seen) begin
        left_r[ridx]  <= col_r;
        right_r[ridx] <= col_r;
      end else begin
        if (col_r < rd_left) begin
          left_r[ridx] <= col_r;
        end
        if (col_r > rd_right) begin
          right_r[ridx] <= col_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/glyph_column_extent.sv */
// Glyph atlas column extent measurement: top level with sequencer, cell table
// and output register. Depends on gce_pkg, gce_tracker and gce_divider.
//
// Load items write the 64-entry cell-to-character table; pixel items carry the
// atlas red channel in raster order. Both are taken only while the block is
// idle. After the last pixel of a band of cell rows the block reports the
// eight cells of that band, cell column 0 first. Each report reads the table
// and the cell's extent, runs the shared bit-serial divider and then offers
// the result; until the last report of the band is taken (later if the result
// side stalls) no item is accepted.
// Writing cell_width or cell_height restarts the frame at the top-left pixel.
`timescale 1ns / 1ps
`default_nettype none

module glyph_column_extent
  import gce_pkg::*;
#(
  parameter int MAX_CELL_SIDE = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_opcode,
  input  wire logic [SLOT_W-1:0]     in_table_slot,
  input  wire logic [CODE_W-1:0]     in_char_code,
  input  wire logic [LEVEL_W-1:0]    in_red_level,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CODE_W-1:0]          out_glyph_code,
  output logic [GRID_W-1:0]          out_grid_column,
  output logic [GRID_W-1:0]          out_grid_row,
  output logic [FRAC_W-1:0]          out_width_fraction,
  output logic                       out_extent_error,
  output logic                       out_last_of_band
);

  localparam int LW = $clog2(MAX_CELL_SIDE);
  localparam int WW = $clog2(MAX_CELL_SIDE + 1);

  // configuration
  logic [CFG_DATA_W-1:0] cell_width_r;
  logic [CFG_DATA_W-1:0] cell_height_r;
  logic [CFG_DATA_W-1:0] lit_threshold_r;
  logic                  cfg_fire;
  logic [WW-1:0]         weff;
  logic [WW-1:0]         heff;

  // sequencer
  seq_state_t        state_r, state_nxt;
  logic [GRID_W-1:0] k_r, k_nxt;
  logic [GRID_W-1:0] band_sel_r, band_sel_nxt;
  logic              err_r;
  logic              in_fire;
  logic              out_fire;

  // cell table
  logic [CODE_W-1:0] table_mem [GRID * GRID];
  logic [CODE_W-1:0] tab_q_r;

  // output register
  logic              out_valid_r;
  logic [CODE_W-1:0] glyph_r;
  logic [GRID_W-1:0] gcol_r;
  logic [GRID_W-1:0] grow_r;
  logic [FRAC_W-1:0] frac_r;
  logic              xerr_r;
  logic              last_r;

  trk_ctrl_t         trk_ctrl;
  trk_stat_t         trk_stat;
  logic              rd_seen;
  logic [LW-1:0]     rd_left;
  logic [LW-1:0]     rd_right;
  logic              div_start;
  logic              div_idle;
  logic [FRAC_W-1:0] div_q;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r    <= CELL_WIDTH_RST;
      cell_height_r   <= CELL_HEIGHT_RST;
      lit_threshold_r <= LIT_THRESHOLD_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_CELL_WIDTH:    cell_width_r    <= cfg_data;
        REG_CELL_HEIGHT:   cell_height_r   <= cfg_data;
        REG_LIT_THRESHOLD: lit_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported cell sides
  always_comb begin
    if (int'(cell_width_r) < 2) begin
      weff = WW'(2);
    end else if (int'(cell_width_r) > MAX_CELL_SIDE) begin
      weff = WW'(MAX_CELL_SIDE);
    end else begin
      weff = WW'(cell_width_r);
    end
    if (cell_height_r == '0) begin
      heff = WW'(1);
    end else if (int'(cell_height_r) > MAX_CELL_SIDE) begin
      heff = WW'(MAX_CELL_SIDE);
    end else begin
      heff = WW'(cell_height_r);
    end
  end

  assign trk_ctrl.px_fire  = in_fire && (in_opcode == OP_PIXEL);
  assign trk_ctrl.px_lit   = (in_red_level > lit_threshold_r);
  assign trk_ctrl.restart  = cfg_fire &&
                             ((cfg_index == REG_CELL_WIDTH) || (cfg_index == REG_CELL_HEIGHT));
  assign trk_ctrl.clr_seen = (state_r == ST_OUT) && out_fire && (k_r == GRID_LAST);

  gce_tracker #(
    .LW (LW),
    .WW (WW)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (trk_ctrl),
    .weff     (weff),
    .heff     (heff),
    .rd_idx   (k_r),
    .stat     (trk_stat),
    .rd_seen  (rd_seen),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  assign div_start = (state_r == ST_READ);

  gce_divider #(
    .LW (LW),
    .WW (WW)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_right - rd_left),
    .divisor  (weff),
    .idle     (div_idle),
    .quotient (div_q)
  );

  // cell table: write on load items, registered read for the reporting cell
  always_ff @(posedge clk) begin
    if (in_fire && (in_opcode == OP_LOAD)) begin
      table_mem[in_table_slot] <= in_char_code;
    end
    tab_q_r <= table_mem[{band_sel_r, k_r}];
  end

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    band_sel_nxt = band_sel_r;
    case (state_r)
      ST_IDLE: begin
        if (trk_stat.band_end) begin
          band_sel_nxt = trk_stat.band;
          k_nxt        = '0;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_idle) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (k_r == GRID_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      band_sel_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      band_sel_r <= band_sel_nxt;
      if ((state_r == ST_DIV) && div_idle) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture the error flag while the extent is on the read port
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      err_r <= !rd_seen || (rd_left == rd_right);
    end
    if ((state_r == ST_DIV) && div_idle) begin
      glyph_r <= tab_q_r;
      gcol_r  <= k_r;
      grow_r  <= band_sel_r;
      frac_r  <= err_r ? '0 : div_q;
      xerr_r  <= err_r;
      last_r  <= (k_r == GRID_LAST);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_glyph_code     = glyph_r;
  assign out_grid_column    = gcol_r;
  assign out_grid_row       = grow_r;
  assign out_width_fraction = frac_r;
  assign out_extent_error   = xerr_r;
  assign out_last_of_band   = last_r;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for glyph_column_extent: drives load and pixel items,
// predicts every cell report and compares them field by field.
// Depends on gce_pkg and the glyph_column_extent RTL.
`timescale 1ns / 1ps

module testbench;
  import gce_pkg::*;

  localparam int SIDE_MAX = 8;
  localparam int SETTLE_CYCLES = 160;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  code;
    logic [LEVEL_W-1:0] level;
  } atlas_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [GRID_W-1:0] col;
    logic [GRID_W-1:0] row;
    logic [FRAC_W-1:0] frac;
    logic              err;
    logic              last;
  } cell_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CELL_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = OP_LOAD;
  logic [SLOT_W-1:0]     in_table_slot = '0;
  logic [CODE_W-1:0]     in_char_code = '0;
  logic [LEVEL_W-1:0]    in_red_level = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CODE_W-1:0]     out_glyph_code;
  logic [GRID_W-1:0]     out_grid_column;
  logic [GRID_W-1:0]     out_grid_row;
  logic [FRAC_W-1:0]     out_width_fraction;
  logic                  out_extent_error;
  logic                  out_last_of_band;

  glyph_column_extent #(.MAX_CELL_SIDE(SIDE_MAX)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_table_slot(in_table_slot), .in_char_code(in_char_code),
    .in_red_level(in_red_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_glyph_code(out_glyph_code), .out_grid_column(out_grid_column),
    .out_grid_row(out_grid_row), .out_width_fraction(out_width_fraction),
    .out_extent_error(out_extent_error), .out_last_of_band(out_last_of_band)
  );

  always #4 clk = ~clk;

  // Scan state of the atlas predictor
  logic [CODE_W-1:0]     atlas_codes [64];
  logic [CFG_DATA_W-1:0] reg_width = CELL_WIDTH_RST;
  logic [CFG_DATA_W-1:0] reg_height = CELL_HEIGHT_RST;
  logic [CFG_DATA_W-1:0] reg_thresh = LIT_THRESHOLD_RST;
  int unsigned scan_x = 0;
  int unsigned scan_y = 0;
  int unsigned ink_lo [GRID] = '{default: 0};
  int unsigned ink_hi [GRID] = '{default: 0};
  bit          ink_any [GRID] = '{default: 0};

  atlas_item_t  pending_items [$];
  cell_report_t reports_due [$];

  bit gaps_on = 1'b1;
  int n_queued = 0;
  int n_accepted = 0;
  int n_pixels = 0;
  int n_loads = 0;
  int n_reports = 0;
  int n_writes = 0;
  int n_phases = 0;
  int fail_count = 0;

  function automatic int unsigned span_w();
    int unsigned w;
    w = reg_width;
    if (w < 2) w = 2;
    if (w > SIDE_MAX) w = SIDE_MAX;
    return w;
  endfunction

  function automatic int unsigned span_h();
    int unsigned h;
    h = reg_height;
    if (h < 1) h = 1;
    if (h > SIDE_MAX) h = SIDE_MAX;
    return h;
  endfunction

  task automatic restart_scan();
    scan_x = 0;
    scan_y = 0;
    ink_any = '{default: 0};
  endtask

  // Advance the raster position by one pixel; queue eight reports at a band end.
  task automatic take_pixel(input logic [LEVEL_W-1:0] level);
    int unsigned w, h, cidx, loc, band;
    cell_report_t r;
    w = span_w();
    h = span_h();
    cidx = (scan_x / w) % GRID;
    loc = scan_x % w;
    if (level > reg_thresh) begin
      if (!ink_any[cidx]) begin
        ink_any[cidx] = 1'b1;
        ink_lo[cidx] = loc;
        ink_hi[cidx] = loc;
      end else begin
        if (loc < ink_lo[cidx]) ink_lo[cidx] = loc;
        if (loc > ink_hi[cidx]) ink_hi[cidx] = loc;
      end
    end
    if (scan_x + 1 < GRID * w) begin
      scan_x++;
    end else begin
      scan_x = 0;
      if ((scan_y + 1) % h == 0) begin
        band = (scan_y / h) % GRID;
        for (int k = 0; k < GRID; k++) begin
          r.code = atlas_codes[band * GRID + k];
          r.col = k[GRID_W-1:0];
          r.row = band[GRID_W-1:0];
          r.err = !ink_any[k] || ink_lo[k] == ink_hi[k];
          r.frac = r.err ? '0 : FRAC_W'(((ink_hi[k] - ink_lo[k]) << 16) / w);
          r.last = (k == GRID - 1);
          reports_due.push_back(r);
          ink_any[k] = 1'b0;
        end
      end
      scan_y = (scan_y + 1 < GRID * h) ? scan_y + 1 : 0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Item driver: hold the payload until accepted, idle at random when enabled
  always @(posedge clk) begin
    atlas_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 24)) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.op;
        in_table_slot <= nxt.slot;
        in_char_code <= nxt.code;
        in_red_level <= nxt.level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 24);
  end

  // Monitor: track register writes and accepted items, check each report
  always @(posedge clk) begin
    cell_report_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_CELL_WIDTH: begin
            reg_width = cfg_data;
            restart_scan();
          end
          REG_CELL_HEIGHT: begin
            reg_height = cfg_data;
            restart_scan();
          end
          REG_LIT_THRESHOLD: reg_thresh = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        if (in_opcode == OP_LOAD) begin
          atlas_codes[in_table_slot] = in_char_code;
          n_loads++;
        end else begin
          take_pixel(in_red_level);
          n_pixels++;
        end
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected report: cell %0d,%0d code %0d",
                 out_grid_row, out_grid_column, out_glyph_code);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          n_reports++;
          check_field("glyph_code", want.code, out_glyph_code);
          check_field("grid_column", want.col, out_grid_column);
          check_field("grid_row", want.row, out_grid_row);
          check_field("width_fraction", want.frac, out_width_fraction);
          check_field("extent_error", want.err, out_extent_error);
          check_field("last_of_band", want.last, out_last_of_band);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_load(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] code);
    atlas_item_t it;
    it.op = OP_LOAD;
    it.slot = slot;
    it.code = code;
    it.level = LEVEL_W'($urandom);
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_pixel(input logic [LEVEL_W-1:0] level);
    atlas_item_t it;
    it.op = OP_PIXEL;
    it.slot = SLOT_W'($urandom);
    it.code = CODE_W'($urandom);
    it.level = level;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Red level on either side of the current threshold
  function automatic logic [LEVEL_W-1:0] ink_level(input bit lit);
    if (!lit) return LEVEL_W'($urandom_range(0, reg_thresh));
    if (reg_thresh == 8'hff) return 8'hff;
    return LEVEL_W'($urandom_range(reg_thresh + 1, 255));
  endfunction

  // Wait for every item and report, then let the block go idle
  task automatic settle();
    while (n_accepted != n_queued || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  initial begin
    int unsigned band_px, remain, nb, start_items, start_reports;
    logic [LEVEL_W-1:0] walk [16];
    walk = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
             8'h80, 8'h7f, 8'h55, 8'haa, 8'h00, 8'h00, 8'hff, 8'h01};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table so no band reads an unwritten entry
    for (int s = 0; s < 64; s++)
      push_load(s[SLOT_W-1:0], (s == 0) ? 8'h00 : (s == 63) ? 8'hff : CODE_W'($urandom));
    settle();

    // Directed band: clamped 2x1 cells, zero threshold, spare index ignored
    write_reg(REG_CELL_WIDTH, 8'd1);
    write_reg(REG_CELL_HEIGHT, 8'd0);
    write_reg(REG_LIT_THRESHOLD, 8'd0);
    write_reg(REG_SPARE, 8'hff);
    for (int i = 0; i < 16; i++) begin
      if (i == 5) push_load(6'd1, 8'hff);
      if (i == 11) push_load(6'd63, 8'h00);
      push_pixel(walk[i]);
    end
    settle();

    // Run past the end of a frame so the position wraps
    write_reg(REG_CELL_WIDTH, 8'd2);
    write_reg(REG_LIT_THRESHOLD, 8'd100);
    for (int i = 0; i < 144; i++) push_pixel(ink_level($urandom_range(0, 99) < 30));
    settle();

    // Widest cells, one band, no idling
    gaps_on = 1'b0;
    write_reg(REG_CELL_WIDTH, 8'd8);
    write_reg(REG_CELL_HEIGHT, 8'd1);
    write_reg(REG_LIT_THRESHOLD, 8'd254);
    for (int i = 0; i < 64; i++) begin
      if (i == 0 || i == 7 || i == 60) push_pixel(8'hff);
      else push_pixel(ink_level($urandom_range(0, 99) < 3));
    end
    settle();
    gaps_on = 1'b1;

    // Oversized geometry: partial band only, the next write restarts it
    write_reg(REG_CELL_WIDTH, 8'hff);
    write_reg(REG_CELL_HEIGHT, 8'hff);
    write_reg(REG_LIT_THRESHOLD, 8'd8);
    for (int i = 0; i < 20; i++) push_pixel(ink_level($urandom_range(0, 99) < 40));
    settle();

    start_items = n_queued;
    start_reports = n_reports;
    while (n_queued - start_items < 40 || n_reports - start_reports < 16) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      remain = (span_h() - scan_y % span_h()) * GRID * span_w() - scan_x;
      if (remain > 300 || $urandom_range(0, 1) == 0)
        write_reg(REG_CELL_WIDTH, ($urandom_range(0, 9) == 0) ?
                  CFG_DATA_W'($urandom_range(0, 1)) : CFG_DATA_W'($urandom_range(2, 5)));
      if (remain > 300 || $urandom_range(0, 2) == 0)
        write_reg(REG_CELL_HEIGHT, ($urandom_range(0, 9) == 0) ?
                  8'd0 : CFG_DATA_W'($urandom_range(1, 3)));
      if ($urandom_range(0, 2) == 0)
        case ($urandom_range(0, 4))
          0: write_reg(REG_LIT_THRESHOLD, 8'd0);
          1: write_reg(REG_LIT_THRESHOLD, 8'hff);
          default: write_reg(REG_LIT_THRESHOLD, CFG_DATA_W'($urandom));
        endcase
      band_px = span_h() * GRID * span_w();
      remain = (span_h() - scan_y % span_h()) * GRID * span_w() - scan_x;
      // Mostly finish whole bands; sometimes stop partway through one
      if ($urandom_range(0, 3) == 0)
        nb = $urandom_range(1, remain);
      else
        nb = remain + $urandom_range(0, 1) * band_px;
      for (int i = 0; i < nb; i++) begin
        if ($urandom_range(0, 99) < 10)
          push_load(SLOT_W'($urandom), CODE_W'($urandom));
        push_pixel(ink_level($urandom_range(0, 99) < 30));
      end
      settle();
    end

    $display("Drove %0d pixels and %0d table loads; checked %0d cell reports.",
             n_pixels, n_loads, n_reports);
    $display("%0d register writes over %0d phases: clamped and full-range geometry, %s",
             n_writes, n_phases, "thresholds 0 to 255, frame wrap and partial bands.");
    if (fail_count == 0)
      $display("glyph_column_extent verification clean");
    else
      $display("glyph_column_extent verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("glyph_column_extent verification failed");
    $finish;
  end

endmodule
